// ===== rtl/esc_pkg.sv =====
// shared constants, codes and helper functions of the elevator scan call scheduler
package esc_pkg;

  localparam int FLOOR_W   = 4;
  localparam int COUNT_W   = 6;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 4;

  localparam int QUEUE_DEPTH_DEF = 32;

  localparam logic [FLOOR_W-1:0] TOP_FLOOR_RST   = 4'd10;
  localparam logic [FLOOR_W-1:0] START_FLOOR_RST = 4'd1;
  localparam logic [FLOOR_W-1:0] MIN_TOP         = 4'd2;
  localparam logic [FLOOR_W-1:0] GROUND_FLOOR    = 4'd1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TOP_FLOOR   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_START_FLOOR = 1'b1;

  // item kinds
  localparam logic KIND_CALL = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  function automatic logic [FLOOR_W-1:0] eff_top(input logic [FLOOR_W-1:0] top);
    eff_top = (top < MIN_TOP) ? MIN_TOP : top;
  endfunction

  function automatic logic [FLOOR_W-1:0] place_car(input logic [FLOOR_W-1:0] start,
                                                   input logic [FLOOR_W-1:0] top);
    logic [FLOOR_W-1:0] t;
    logic [FLOOR_W-1:0] f;
    t = eff_top(top);
    f = (start < GROUND_FLOOR) ? GROUND_FLOOR : start;
    place_car = (f > t) ? t : f;
  endfunction

endpackage

// ===== rtl/esc_if.sv =====
// request and response channel interfaces of the elevator scan call scheduler
interface esc_req_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [esc_pkg::FLOOR_W-1:0] call_floor;

  modport source (output valid, kind, call_floor, input ready);
  modport sink (input valid, kind, call_floor, output ready);
endinterface

interface esc_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        call_accepted;
  logic [esc_pkg::COUNT_W-1:0] served_count;
  logic [esc_pkg::FLOOR_W-1:0] served_floor;
  logic                        served_going_up;
  logic [esc_pkg::FLOOR_W-1:0] new_floor;
  logic                        new_going_up;
  logic [esc_pkg::COUNT_W-1:0] pending_count;

  modport source (output valid, call_accepted, served_count, served_floor, served_going_up,
                  new_floor, new_going_up, pending_count, input ready);
  modport sink (input valid, call_accepted, served_count, served_floor, served_going_up,
                new_floor, new_going_up, pending_count, output ready);
endinterface

// ===== rtl/esc_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
module esc_ram #(
  parameter int WIDTH = esc_pkg::FLOOR_W,
  parameter int DEPTH = esc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/elevator_scan_call_scheduler.sv =====
// Elevator call scheduler (SCAN). Pending calls live in a QUEUE_DEPTH x 4 ram in arrival
// order. A call item is written at the tail in the accept cycle and its result is registered
// in ST_FIN. For a tick with calls pending, the scan reads one entry per cycle from the
// ram's read port, serves entries for the car's floor and writes the others back compacted
// through the write port, then ST_MOVE updates direction and floor. A tick with nothing
// pending skips the scan and the move and goes straight to ST_FIN. One item is in work at
// a time; the result register lets the next item start before the result is taken, and an
// item only waits at its end if the previous result is still unclaimed.
module elevator_scan_call_scheduler #(
  parameter int QUEUE_DEPTH = esc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [esc_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [esc_pkg::CFG_W-1:0]     wr_data,
  esc_req_if.sink                       req,
  esc_rsp_if.source                     rsp
);

  localparam int AW    = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int FW    = esc_pkg::FLOOR_W;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_MOVE = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t            state;
  logic [FW-1:0]     top_floor;
  logic [FW-1:0]     car_floor;
  logic              car_up;
  logic [CNT_W-1:0]  total;
  logic [CNT_W-1:0]  chk;
  logic [CNT_W-1:0]  keep;
  logic [CNT_W-1:0]  served;
  logic              above;
  logic              below;

  logic              res_acc;
  logic [CNT_W-1:0]  res_served;
  logic [FW-1:0]     res_srv_floor;
  logic              res_srv_up;

  logic              out_valid;
  logic              out_acc;
  logic [esc_pkg::COUNT_W-1:0] out_served;
  logic [FW-1:0]     out_srv_floor;
  logic              out_srv_up;
  logic [FW-1:0]     out_new_floor;
  logic              out_new_up;
  logic [esc_pkg::COUNT_W-1:0] out_pending;

  logic              req_fire;
  logic              call_ok;
  logic [FW-1:0]     top_eff;
  logic [CNT_W-1:0]  chk_next;
  logic              last;
  logic              match;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [FW-1:0]     ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [FW-1:0]     ram_rdata;

  logic              up_turn;
  logic [FW:0]       step_floor;
  logic [FW-1:0]     floor_next;
  logic              up_next;

  assign req.ready = (state == ST_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign top_eff   = esc_pkg::eff_top(top_floor);
  assign call_ok   = (req.call_floor >= esc_pkg::GROUND_FLOOR) && (req.call_floor <= top_eff)
                     && (total < CNT_W'(QUEUE_DEPTH));
  assign chk_next  = chk + CNT_W'(1);
  assign last      = (chk == total - CNT_W'(1));
  assign match     = (ram_rdata == car_floor);

  // tail write on an accepted call, compacting write-back during the scan
  always_comb begin
    if (state == ST_SCAN) begin
      ram_we    = !match;
      ram_waddr = keep[AW-1:0];
      ram_wdata = ram_rdata;
      ram_raddr = chk_next[AW-1:0];
    end else begin
      ram_we    = req_fire && (req.kind == esc_pkg::KIND_CALL) && call_ok;
      ram_waddr = total[AW-1:0];
      ram_wdata = req.call_floor;
      ram_raddr = '0;
    end
  end

  esc_ram #(
    .WIDTH (FW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // reverse when nothing lies ahead, then step and clamp
  always_comb begin
    up_turn = car_up;
    if (!above && car_up) begin
      up_turn = 1'b0;
    end else if (!below && !car_up) begin
      up_turn = 1'b1;
    end
    step_floor = up_turn ? ({1'b0, car_floor} + (FW+1)'(1)) : ({1'b0, car_floor} - (FW+1)'(1));
    floor_next = step_floor[FW-1:0];
    up_next    = up_turn;
    if (step_floor > {1'b0, top_eff}) begin
      floor_next = top_eff;
      up_next    = 1'b0;
    end else if (step_floor == '0) begin
      floor_next = esc_pkg::GROUND_FLOOR;
      up_next    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      top_floor   <= esc_pkg::TOP_FLOOR_RST;
      car_floor   <= esc_pkg::place_car(esc_pkg::START_FLOOR_RST, esc_pkg::TOP_FLOOR_RST);
      car_up      <= 1'b1;
      total       <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && (state != ST_FIN)) begin
        out_valid <= 1'b0;
      end
      if (wr_en) begin
        case (wr_index)
          esc_pkg::REG_TOP_FLOOR: begin
            top_floor <= wr_data;
          end
          esc_pkg::REG_START_FLOOR: begin
            car_floor <= esc_pkg::place_car(wr_data, top_floor);
          end
          default: begin
          end
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (req_fire) begin
            res_srv_floor <= car_floor;
            res_srv_up    <= car_up;
            res_served    <= '0;
            res_acc       <= (req.kind == esc_pkg::KIND_CALL) && call_ok;
            if (req.kind == esc_pkg::KIND_CALL) begin
              if (call_ok) begin
                total <= total + CNT_W'(1);
              end
              state <= ST_FIN;
            end else if (total == '0) begin
              state <= ST_FIN;
            end else begin
              chk    <= '0;
              keep   <= '0;
              served <= '0;
              above  <= 1'b0;
              below  <= 1'b0;
              state  <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (match) begin
            served <= served + CNT_W'(1);
          end else begin
            keep <= keep + CNT_W'(1);
            if (ram_rdata > car_floor) begin
              above <= 1'b1;
            end
            if (ram_rdata < car_floor) begin
              below <= 1'b1;
            end
          end
          chk <= chk_next;
          if (last) begin
            state <= ST_MOVE;
          end
        end
        ST_MOVE: begin
          car_floor  <= floor_next;
          car_up     <= up_next;
          total      <= keep;
          res_served <= served;
          state      <= ST_FIN;
        end
        ST_FIN: begin
          if (!out_valid || rsp.ready) begin
            out_valid     <= 1'b1;
            out_acc       <= res_acc;
            out_served    <= esc_pkg::COUNT_W'(res_served);
            out_srv_floor <= res_srv_floor;
            out_srv_up    <= res_srv_up;
            out_new_floor <= car_floor;
            out_new_up    <= car_up;
            out_pending   <= esc_pkg::COUNT_W'(total);
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.call_accepted   = out_acc;
  assign rsp.served_count    = out_served;
  assign rsp.served_floor    = out_srv_floor;
  assign rsp.served_going_up = out_srv_up;
  assign rsp.new_floor       = out_new_floor;
  assign rsp.new_going_up    = out_new_up;
  assign rsp.pending_count   = out_pending;

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= CNT_W'(QUEUE_DEPTH))
    else $error("pending total above queue depth");

  a_car_floor: assert property (@(posedge clk) disable iff (rst)
    car_floor != '0)
    else $error("car at floor zero");

  a_keep_chk: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (keep <= chk) && (chk < total))
    else $error("compaction write index ahead of scan");

  a_call_served: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_acc |-> out_served == '0)
    else $error("call item reports served calls");

  a_scan_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MOVE) |-> $past(state == ST_SCAN) && (keep + served == total))
    else $error("scan lost or duplicated entries");

endmodule

// ===== sim/esc_call_checker.sv =====
// checker for the elevator scan call scheduler: watches the channels, predicts and compares
`timescale 1ns / 100ps

module esc_call_checker #(
  parameter int QUEUE_DEPTH = esc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [esc_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [esc_pkg::CFG_W-1:0]     wr_data,
  esc_req_if                            req,
  esc_rsp_if                            rsp,
  output int                            mismatches,
  output int                            outstanding
);
  import esc_pkg::*;

  typedef logic [FLOOR_W-1:0] floor_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef struct packed {
    logic   call_accepted;
    count_t served_count;
    floor_t served_floor;
    logic   served_going_up;
    floor_t new_floor;
    logic   new_going_up;
    count_t pending_count;
  } car_report_t;

  // own copy of the scheduler state and registers
  floor_t top_reg;
  floor_t start_reg;
  floor_t waiting_floors [QUEUE_DEPTH];
  int     waiting_total;
  floor_t car_at;
  logic   car_up;

  car_report_t expected_reports [$];
  car_report_t want;
  car_report_t got;

  function automatic floor_t floor_limit();
    return (top_reg < MIN_TOP) ? MIN_TOP : top_reg;
  endfunction

  task automatic put_car();
    floor_t f;
    floor_t lim;
    lim = floor_limit();
    f = (start_reg < GROUND_FLOOR) ? GROUND_FLOOR : start_reg;
    car_at = (f > lim) ? lim : f;
  endtask

  task automatic schedule_item(input logic k, input floor_t f, output car_report_t rpt);
    floor_t lim;
    int     keep;
    int     served;
    int     next;
    logic   above;
    logic   below;
    lim = floor_limit();
    served = 0;
    rpt = '0;
    rpt.served_floor = car_at;
    rpt.served_going_up = car_up;
    if (k == KIND_CALL) begin
      if (f >= GROUND_FLOOR && f <= lim && waiting_total < QUEUE_DEPTH) begin
        waiting_floors[waiting_total] = f;
        waiting_total++;
        rpt.call_accepted = 1'b1;
      end
    end else if (waiting_total > 0) begin
      keep = 0;
      above = 1'b0;
      below = 1'b0;
      // serve calls at the car's floor, compact the rest in arrival order
      for (int i = 0; i < waiting_total; i++) begin
        if (waiting_floors[i] == car_at) begin
          served++;
        end else begin
          if (waiting_floors[i] > car_at) above = 1'b1;
          if (waiting_floors[i] < car_at) below = 1'b1;
          waiting_floors[keep] = waiting_floors[i];
          keep++;
        end
      end
      waiting_total = keep;
      if (!above && car_up) begin
        car_up = 1'b0;
      end else if (!below && !car_up) begin
        car_up = 1'b1;
      end
      next = int'(car_at) + (car_up ? 1 : -1);
      if (next > int'(lim)) begin
        next = int'(lim);
        car_up = 1'b0;
      end else if (next < 1) begin
        next = 1;
        car_up = 1'b1;
      end
      car_at = floor_t'(next);
    end
    rpt.served_count = count_t'(served);
    rpt.new_floor = car_at;
    rpt.new_going_up = car_up;
    rpt.pending_count = count_t'(waiting_total);
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      top_reg = TOP_FLOOR_RST;
      start_reg = START_FLOOR_RST;
      waiting_total = 0;
      car_up = 1'b1;
      put_car();
      expected_reports.delete();
      mismatches = 0;
    end else begin
      if (wr_en) begin
        if (wr_index == REG_TOP_FLOOR) begin
          top_reg = floor_t'(wr_data);
        end else if (wr_index == REG_START_FLOOR) begin
          start_reg = floor_t'(wr_data);
          put_car();
        end
      end
      if (req.valid && req.ready) begin
        schedule_item(req.kind, req.call_floor, want);
        expected_reports.push_back(want);
      end
      if (rsp.valid && rsp.ready) begin
        got.call_accepted = rsp.call_accepted;
        got.served_count = rsp.served_count;
        got.served_floor = rsp.served_floor;
        got.served_going_up = rsp.served_going_up;
        got.new_floor = rsp.new_floor;
        got.new_going_up = rsp.new_going_up;
        got.pending_count = rsp.pending_count;
        if (expected_reports.size() == 0) begin
          $error("result item with no expectation waiting");
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          check_field("call_accepted", want.call_accepted, got.call_accepted);
          check_field("served_count", want.served_count, got.served_count);
          check_field("served_floor", want.served_floor, got.served_floor);
          check_field("served_going_up", want.served_going_up, got.served_going_up);
          check_field("new_floor", want.new_floor, got.new_floor);
          check_field("new_going_up", want.new_going_up, got.new_going_up);
          check_field("pending_count", want.pending_count, got.pending_count);
        end
      end
    end
    outstanding = expected_reports.size();
  end

endmodule

// ===== sim/elevator_scan_call_scheduler_tb.sv =====
// testbench top of the elevator scan call scheduler: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module elevator_scan_call_scheduler_tb;
  import esc_pkg::*;

  typedef logic [FLOOR_W-1:0] floor_t;

  localparam int DEPTH       = QUEUE_DEPTH_DEF;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE      = 6;
  localparam int TAIL        = 40;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 wr_en;
  logic [CFG_IDX_W-1:0] wr_index;
  logic [CFG_W-1:0]     wr_data;

  int     mismatches;
  int     outstanding;
  int     idle_cycles = 0;
  bit     calm = 1'b0;
  bit     hold_req = 1'b0;
  floor_t cur_top = TOP_FLOOR_RST;

  esc_req_if req_ch ();
  esc_rsp_if rsp_ch ();

  elevator_scan_call_scheduler #(
    .QUEUE_DEPTH(DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .req      (req_ch),
    .rsp      (rsp_ch)
  );

  esc_call_checker #(
    .QUEUE_DEPTH(DEPTH)
  ) checker_i (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #4 clk = ~clk;

  // receiver: random stalls, or one long hold-off on request
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        rsp_ch.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        rsp_ch.ready = calm || ($urandom_range(0, 99) >= 25);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  function automatic floor_t highest_call();
    return (cur_top < MIN_TOP) ? MIN_TOP : cur_top;
  endfunction

  // entered and left at a falling edge
  task automatic send_item(input logic k, input floor_t f);
    while (!calm && $urandom_range(0, 99) < 25) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid = 1'b1;
    req_ch.kind = k;
    req_ch.call_floor = f;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    wr_en = 1'b1;
    wr_index = idx;
    wr_data = val;
    @(negedge clk);
    wr_en = 1'b0;
  endtask

  // sender stops and waits for every expected result
  task automatic wait_idle();
    req_ch.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      send_item(KIND_CALL, floor_t'($urandom_range(0, 15)));
    end else if (r < 60) begin
      send_item(KIND_CALL, floor_t'($urandom_range(1, highest_call())));
    end else begin
      send_item(KIND_TICK, floor_t'($urandom_range(0, 15)));
    end
  endtask

  task automatic run_phase(input floor_t top, input floor_t start, input int n,
                           input bit fill, input bit quiet, input bit hold);
    write_reg(REG_TOP_FLOOR, top);
    cur_top = top;
    write_reg(REG_START_FLOOR, start);
    calm = quiet;
    for (int i = 0; i < n; i++) begin
      if (hold && i == n / 3) hold_req = 1'b1;
      // a burst of valid calls overflows the pending list
      if (fill && i < DEPTH + 3) begin
        send_item(KIND_CALL, floor_t'($urandom_range(1, highest_call())));
      end else begin
        random_item();
      end
    end
    wait_idle();
  endtask

  initial begin
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    req_ch.valid = 1'b0;
    req_ch.kind = KIND_CALL;
    req_ch.call_floor = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // reset settings: top 10, car at 1
    send_item(KIND_TICK, 4'd0);
    send_item(KIND_CALL, 4'd0);
    send_item(KIND_CALL, 4'd11);
    send_item(KIND_CALL, 4'd15);
    send_item(KIND_CALL, 4'd10);
    send_item(KIND_CALL, 4'd1);
    send_item(KIND_CALL, 4'd5);
    send_item(KIND_CALL, 4'd5);
    send_item(KIND_TICK, 4'd15);
    repeat (11) send_item(KIND_TICK, 4'd0);
    wait_idle();

    // top lowered under the car: clamp on the next step
    write_reg(REG_TOP_FLOOR, 4'd15);
    write_reg(REG_START_FLOOR, 4'd15);
    write_reg(REG_TOP_FLOOR, 4'd4);
    cur_top = 4'd4;
    send_item(KIND_CALL, 4'd2);
    send_item(KIND_TICK, 4'd0);
    send_item(KIND_TICK, 4'd0);
    wait_idle();

    run_phase(4'd15, 4'd15, 70, 1'b0, 1'b0, 1'b1);
    run_phase(4'd2, 4'd1, 70, 1'b0, 1'b0, 1'b0);
    run_phase(4'd0, 4'd0, 50, 1'b0, 1'b0, 1'b0);
    run_phase(4'd1, 4'd9, 50, 1'b1, 1'b0, 1'b0);
    run_phase(4'd7, 4'd4, 90, 1'b1, 1'b1, 1'b0);
    run_phase(4'd15, 4'd1, 120, 1'b1, 1'b0, 1'b1);
    run_phase(4'd5, 4'd15, 70, 1'b0, 1'b0, 1'b0);
    run_phase(4'd12, 4'd6, 80, 1'b0, 1'b0, 1'b0);

    repeat (TAIL) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
